// ===== src/cmdil_pkg.sv =====
// shared constants and types of the color match dilation unit
// used by every module of the block; no dependencies
`default_nettype none

package cmdil_pkg;

    // frame and window limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 2;
    localparam int LINES      = 2 * MAX_RADIUS + 1;

    // derived widths
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int DIMW_W    = $clog2(MAX_WIDTH + 1);
    localparam int DIMH_W    = $clog2(MAX_HEIGHT + 1);
    localparam int SLOT_W    = $clog2(LINES);
    localparam int RR_W      = $clog2(MAX_RADIUS + 1);
    localparam int PIX_DEPTH = LINES * MAX_WIDTH;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int LAG_W     = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

    // fixed field widths
    localparam int PIX_W  = 24;
    localparam int RAD_W  = 2;
    localparam int SIZE_W = 13;
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;

    // register indexes of the configuration port
    typedef enum logic [CFG_AW-1:0] {
        REG_MATCH_COLOR,
        REG_RADIUS,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_reg_t;

    // command codes carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one item leaving the position stage
    typedef struct packed {
        logic              valid;
        logic              push;       // pixel written, its column enters the window
        logic              emit;       // an output pixel leaves with this item
        logic              edge_px;    // output pixel lies within r of a frame edge
        logic              last;       // output pixel closes the frame
        logic              cur_match;  // match bit of the incoming pixel
        logic [SLOT_W-1:0] slot;       // line slot of the incoming pixel
        logic              fwd;        // delay read hits the entry written this cycle
        logic [PIX_W-1:0]  px;
    } s0_item_t;

    // match line store access
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] slot;
        logic [COL_W-1:0]  col;
        logic              bit_val;
    } match_req_t;

    // pixel delay store access
    typedef struct packed {
        logic              wr_en;
        logic [PIX_AW-1:0] waddr;
        logic [PIX_W-1:0]  wdata;
        logic              rd_en;
        logic [PIX_AW-1:0] raddr;
    } pix_req_t;

endpackage

`default_nettype wire

// ===== src/cmdil_match_mem.sv =====
// match line store: one bit per line slot and column, read as a whole column
// depends on cmdil_pkg
`default_nettype none

module cmdil_match_mem (
    input  wire logic                                aclk,
    input  wire cmdil_pkg::match_req_t               req,
    output logic [cmdil_pkg::LINES-1:0]              rd_bits
);

    logic [cmdil_pkg::LINES-1:0] mem [cmdil_pkg::MAX_WIDTH];
    logic [cmdil_pkg::LINES-1:0] rd_reg;

    // bit write into the slot of the current line, column read of all slots
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.col][req.slot] <= req.bit_val;
        end
        if (req.rd_en) begin
            rd_reg <= mem[req.col];
        end
    end

    assign rd_bits = rd_reg;

endmodule

`default_nettype wire

// ===== src/cmdil_pixel_mem.sv =====
// pixel delay store: line slot by column, one write and one read port
// depends on cmdil_pkg
`default_nettype none

module cmdil_pixel_mem (
    input  wire logic                            aclk,
    input  wire cmdil_pkg::pix_req_t             req,
    output logic [cmdil_pkg::PIX_W-1:0]          rd_data
);

    logic [cmdil_pkg::PIX_W-1:0] mem [cmdil_pkg::PIX_DEPTH];
    logic [cmdil_pkg::PIX_W-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== src/cmdil_ctrl.sv =====
// configuration registers, input and output position counters, emit decision
// depends on cmdil_pkg; drives the two stores and the window stage
`default_nettype none

module cmdil_ctrl (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [cmdil_pkg::CFG_AW-1:0]         cfg_addr,
    input  wire logic [cmdil_pkg::CFG_DW-1:0]         cfg_wdata,
    input  wire logic                                 accept,
    input  wire logic                                 command,
    input  wire logic [cmdil_pkg::PIX_W-1:0]          pixel_in,
    output logic [cmdil_pkg::PIX_W-1:0]               match_color,
    output logic [cmdil_pkg::SLOT_W-1:0]              win_span,
    output cmdil_pkg::s0_item_t                       item,
    output cmdil_pkg::match_req_t                     mreq,
    output cmdil_pkg::pix_req_t                       preq
);

    localparam int COL_W  = cmdil_pkg::COL_W;
    localparam int ROW_W  = cmdil_pkg::ROW_W;
    localparam int DIMW_W = cmdil_pkg::DIMW_W;
    localparam int DIMH_W = cmdil_pkg::DIMH_W;
    localparam int SLOT_W = cmdil_pkg::SLOT_W;
    localparam int RR_W   = cmdil_pkg::RR_W;
    localparam int LAG_W  = cmdil_pkg::LAG_W;
    localparam int PIX_AW = cmdil_pkg::PIX_AW;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        n = (s == SLOT_W'(cmdil_pkg::LINES - 1)) ? '0 : s + SLOT_W'(1);
        return n;
    endfunction

    // configuration
    logic [cmdil_pkg::PIX_W-1:0]  match_color_reg;
    logic [cmdil_pkg::RAD_W-1:0]  radius_reg;
    logic [cmdil_pkg::SIZE_W-1:0] width_reg;
    logic [cmdil_pkg::SIZE_W-1:0] height_reg;
    logic                         geom_wr;

    // positions
    logic [DIMH_W-1:0] in_row_reg,   in_row_next;
    logic [COL_W-1:0]  in_col_reg,   in_col_next;
    logic [SLOT_W-1:0] in_slot_reg,  in_slot_next;
    logic [ROW_W-1:0]  out_row_reg,  out_row_next;
    logic [COL_W-1:0]  out_col_reg,  out_col_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [LAG_W-1:0]  pend_reg,     pend_next;

    logic [DIMW_W-1:0] w_eff;
    logic [DIMH_W-1:0] h_eff;
    logic [RR_W-1:0]   r_eff;
    logic [LAG_W-1:0]  lag;
    logic              complete;
    logic              wr_pix;
    logic              emit;
    logic              in_row_end;
    logic              out_row_end;
    logic              last;
    logic              edge_px;
    logic              cur_match;
    logic [PIX_AW-1:0] waddr;
    logic [PIX_AW-1:0] raddr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_color_reg <= '0;
            radius_reg      <= cmdil_pkg::RAD_W'(1);
            width_reg       <= cmdil_pkg::SIZE_W'(4096);
            height_reg      <= cmdil_pkg::SIZE_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                cmdil_pkg::REG_MATCH_COLOR:  match_color_reg <= cfg_wdata[cmdil_pkg::PIX_W-1:0];
                cmdil_pkg::REG_RADIUS:       radius_reg      <= cfg_wdata[cmdil_pkg::RAD_W-1:0];
                cmdil_pkg::REG_IMAGE_WIDTH:  width_reg       <= cfg_wdata[cmdil_pkg::SIZE_W-1:0];
                cmdil_pkg::REG_IMAGE_HEIGHT: height_reg      <= cfg_wdata[cmdil_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign geom_wr = cfg_wr_en && (cfg_addr inside {cmdil_pkg::REG_RADIUS,
                                                    cmdil_pkg::REG_IMAGE_WIDTH,
                                                    cmdil_pkg::REG_IMAGE_HEIGHT});

    // clamped geometry
    always_comb begin
        if (width_reg == '0) begin
            w_eff = DIMW_W'(1);
        end else if (width_reg > cmdil_pkg::MAX_WIDTH) begin
            w_eff = DIMW_W'(cmdil_pkg::MAX_WIDTH);
        end else begin
            w_eff = DIMW_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = DIMH_W'(1);
        end else if (height_reg > cmdil_pkg::MAX_HEIGHT) begin
            h_eff = DIMH_W'(cmdil_pkg::MAX_HEIGHT);
        end else begin
            h_eff = DIMH_W'(height_reg);
        end
        if (radius_reg > cmdil_pkg::MAX_RADIUS) begin
            r_eff = RR_W'(cmdil_pkg::MAX_RADIUS);
        end else begin
            r_eff = RR_W'(radius_reg);
        end
    end

    // pixels between input and output: r rows plus r pixels
    assign lag      = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);
    assign win_span = SLOT_W'({r_eff, 1'b0});

    assign complete  = in_row_reg >= h_eff;
    assign wr_pix    = accept && !complete && (command == cmdil_pkg::CMD_PIXEL);
    assign emit      = (wr_pix && (pend_reg >= lag)) || (accept && complete);
    assign cur_match = pixel_in == match_color_reg;

    assign in_row_end  = (DIMW_W'(in_col_reg) + DIMW_W'(1)) >= w_eff;
    assign out_row_end = (DIMW_W'(out_col_reg) + DIMW_W'(1)) >= w_eff;
    assign last        = ((DIMH_W'(out_row_reg) + DIMH_W'(1)) >= h_eff) && out_row_end;

    // output pixel inside the frame by at least r on every side
    always_comb begin
        logic row_ok;
        logic col_ok;
        row_ok  = (DIMH_W'(out_row_reg) >= DIMH_W'(r_eff))
               && ((DIMH_W+1)'(out_row_reg) + (DIMH_W+1)'(r_eff) < (DIMH_W+1)'(h_eff));
        col_ok  = (DIMW_W'(out_col_reg) >= DIMW_W'(r_eff))
               && ((DIMW_W+1)'(out_col_reg) + (DIMW_W+1)'(r_eff) < (DIMW_W+1)'(w_eff));
        edge_px = !(row_ok && col_ok);
    end

    always_comb begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        pend_next     = pend_reg;
        if (wr_pix) begin
            if (in_row_end) begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + DIMH_W'(1);
                in_slot_next = slot_inc(in_slot_reg);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (!emit) begin
                pend_next = pend_reg + LAG_W'(1);
            end
        end
        if (emit) begin
            if (out_row_end) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + ROW_W'(1);
                out_slot_next = slot_inc(out_slot_reg);
            end else begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
        // frame done or geometry changed: start over at the origin
        if ((emit && last) || geom_wr) begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_slot_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_slot_next = '0;
            pend_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= '0;
        end else begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            pend_reg     <= pend_next;
        end
    end

    assign waddr = PIX_AW'(in_slot_reg) * PIX_AW'(cmdil_pkg::MAX_WIDTH) + PIX_AW'(in_col_reg);
    assign raddr = PIX_AW'(out_slot_reg) * PIX_AW'(cmdil_pkg::MAX_WIDTH) + PIX_AW'(out_col_reg);

    always_comb begin
        mreq.wr_en   = wr_pix;
        mreq.rd_en   = wr_pix;
        mreq.slot    = in_slot_reg;
        mreq.col     = in_col_reg;
        mreq.bit_val = cur_match;

        preq.wr_en = wr_pix;
        preq.waddr = waddr;
        preq.wdata = pixel_in;
        preq.rd_en = emit;
        preq.raddr = raddr;

        item.valid     = wr_pix || emit;
        item.push      = wr_pix;
        item.emit      = emit;
        item.edge_px   = edge_px;
        item.last      = last;
        item.cur_match = cur_match;
        item.slot      = in_slot_reg;
        item.fwd       = wr_pix && emit && (waddr == raddr);
        item.px        = pixel_in;
    end

    assign match_color = match_color_reg;

endmodule

`default_nettype wire

// ===== src/cmdil_window.sv =====
// window stage: column shift register, window match test, output register
// depends on cmdil_pkg; fed by cmdil_ctrl and the two stores
`default_nettype none

module cmdil_window (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cmdil_pkg::s0_item_t                 item,
    input  wire logic [cmdil_pkg::LINES-1:0]         match_rd,
    input  wire logic [cmdil_pkg::PIX_W-1:0]         pix_rd,
    input  wire logic [cmdil_pkg::PIX_W-1:0]         match_color,
    input  wire logic [cmdil_pkg::SLOT_W-1:0]        win_span,
    output logic                                     s_ready,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [cmdil_pkg::PIX_W-1:0]              m_data,
    output logic                                     m_last
);

    localparam int LINES  = cmdil_pkg::LINES;
    localparam int SLOT_W = cmdil_pkg::SLOT_W;
    localparam int NCOL   = LINES - 1;

    // slot of the line d rows above the given one
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                    input int unsigned d);
        logic [SLOT_W:0] t;
        t = {1'b0, s} + (SLOT_W+1)'(LINES) - (SLOT_W+1)'(d);
        if (t >= (SLOT_W+1)'(LINES)) begin
            t = t - (SLOT_W+1)'(LINES);
        end
        return t[SLOT_W-1:0];
    endfunction

    logic                        s1_valid_reg;
    cmdil_pkg::s0_item_t         s1_reg;
    logic [LINES-1:0]            col_reg [NCOL];
    logic [LINES-1:0]            col_vec;
    logic                        hit;
    logic                        adv_out;
    logic                        move;
    logic [cmdil_pkg::PIX_W-1:0] pix_src;
    logic [cmdil_pkg::PIX_W-1:0] out_pix;
    logic                        m_valid_reg;
    logic [cmdil_pkg::PIX_W-1:0] m_data_reg;
    logic                        m_last_reg;

    assign adv_out = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || adv_out;
    assign move    = s1_valid_reg && adv_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_reg <= item;
        end
    end

    // column vector, bit d = match of the line d rows above the incoming one
    always_comb begin
        col_vec[0] = s1_reg.cur_match;
        for (int d = 1; d < LINES; d++) begin
            col_vec[d] = match_rd[slot_back(s1_reg.slot, d)];
        end
    end

    // any match inside the (2r+1) square, newest column first
    always_comb begin
        logic [LINES-1:0] c;
        hit = 1'b0;
        for (int j = 0; j < LINES; j++) begin
            c = (j == 0) ? col_vec : col_reg[(j == 0) ? 0 : j - 1];
            for (int d = 0; d < LINES; d++) begin
                if (SLOT_W'(j) <= win_span && SLOT_W'(d) <= win_span && c[d]) begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign pix_src = s1_reg.fwd ? s1_reg.px : pix_rd;
    assign out_pix = (!s1_reg.edge_px && hit) ? match_color : pix_src;

    always_ff @(posedge aclk) begin
        if (move && s1_reg.push) begin
            col_reg[0] <= col_vec;
            for (int k = 1; k < NCOL; k++) begin
                col_reg[k] <= col_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv_out) begin
            m_valid_reg <= s1_valid_reg && s1_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            m_data_reg <= out_pix;
            m_last_reg <= s1_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

// ===== src/color_match_dilation_unit.sv =====
// top level of the color match dilation unit
// depends on cmdil_pkg, cmdil_ctrl, cmdil_match_mem, cmdil_pixel_mem, cmdil_window
//
// streaming dilation of a raster frame of 24-bit pixels: an output pixel becomes
// match_color when any pixel of the (2r+1) square around it equals match_color,
// otherwise it is the input pixel; pixels within r of a frame edge pass through.
// sustained rate is one transfer per clock in each direction while m_tready is high;
// the stores have one write and one read port each; each transfer touches each port
// at most once. the output pixel that a transfer releases is loaded into the output
// register at the clock edge after that transfer, unless the output side is stalled;
// the data lag is r rows plus r pixels, so output pixel k leaves with input
// pixel k + r*W + r, and after the last input pixel every transfer on the
// input side (flush or pixel, the pixel discarded) releases one pending output.
// a flush before the frame is complete does nothing. the match and pixel stores
// are never cleared: every entry whose value is used was written earlier in the
// same frame, so no clearing pass follows reset. writing radius, image_width or
// image_height restarts the frame; configure only while the block is idle.
`default_nettype none

module color_match_dilation_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [cmdil_pkg::CFG_AW-1:0]        cfg_addr,
    input  wire logic [cmdil_pkg::CFG_DW-1:0]        cfg_wdata,
    // pixel input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [23:0]                         s_tdata,   // [23:0] pixel_in
    input  wire logic                                s_tuser,   // [0] command: 1 = flush
    // dilated output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [23:0]                              m_tdata,   // [23:0] pixel_out
    output logic                                     m_tlast    // frame_last
);

    logic                                 accept;
    logic [cmdil_pkg::PIX_W-1:0]          match_color;
    logic [cmdil_pkg::SLOT_W-1:0]         win_span;
    cmdil_pkg::s0_item_t                  item;
    cmdil_pkg::match_req_t                mreq;
    cmdil_pkg::pix_req_t                  preq;
    logic [cmdil_pkg::LINES-1:0]          match_rd;
    logic [cmdil_pkg::PIX_W-1:0]          pix_rd;

    // input transfer
    assign accept = s_tvalid && s_tready;

    // positions, emit decision and store addressing
    cmdil_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .command     (s_tuser),
        .pixel_in    (s_tdata),
        .match_color (match_color),
        .win_span    (win_span),
        .item        (item),
        .mreq        (mreq),
        .preq        (preq)
    );

    // match bits of the last 2*MAX_RADIUS+1 lines
    cmdil_match_mem u_match_mem (
        .aclk    (aclk),
        .req     (mreq),
        .rd_bits (match_rd)
    );

    // delayed pixels of the last 2*MAX_RADIUS+1 lines
    cmdil_pixel_mem u_pixel_mem (
        .aclk    (aclk),
        .req     (preq),
        .rd_data (pix_rd)
    );

    // window test and output register, owns the backpressure chain
    cmdil_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (item),
        .match_rd    (match_rd),
        .pix_rd      (pix_rd),
        .match_color (match_color),
        .win_span    (win_span),
        .s_ready     (s_tready),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_data      (m_tdata),
        .m_last      (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/tb_color_match_dilation_unit.sv =====
// testbench of color_match_dilation_unit: directed frames and random frame streams,
// every output transfer checked against a transfer-level dilation predictor
// depends on cmdil_pkg and the rtl of color_match_dilation_unit
`default_nettype none

module tb_color_match_dilation_unit;

    localparam int PIX_W      = cmdil_pkg::PIX_W;
    localparam int RAD_W      = cmdil_pkg::RAD_W;
    localparam int SIZE_W     = cmdil_pkg::SIZE_W;
    localparam int CFG_AW     = cmdil_pkg::CFG_AW;
    localparam int CFG_DW     = cmdil_pkg::CFG_DW;
    localparam int LINES      = cmdil_pkg::LINES;
    localparam int MAX_WIDTH  = cmdil_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT = cmdil_pkg::MAX_HEIGHT;
    localparam int MAX_RADIUS = cmdil_pkg::MAX_RADIUS;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STEADY_FROM  = 1700;

    // one input transfer: command in tuser, pixel in tdata
    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] px;
    } pix_xfer_t;

    // one output pixel as the block should deliver it
    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic             last;
    } dilated_px_t;

    // dut ports
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;     // [23:0] pixel_in
    logic              s_tuser   = 1'b0;   // [0] command: 1 = flush
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;            // [23:0] pixel_out
    logic              m_tlast;            // frame_last

    // stimulus and scoreboard
    pix_xfer_t   pending_xfers[$];
    dilated_px_t owed_pixels[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          sent        = 0;
    int          feed_gap    = 0;
    int          sink_stall  = 0;
    bit          steady      = 1'b0;

    // predictor copy of the registers, at their reset values
    logic [PIX_W-1:0]  key_color  = '0;
    logic [RAD_W-1:0]  win_radius = 2'd1;
    logic [SIZE_W-1:0] frame_w    = 13'd4096;
    logic [SIZE_W-1:0] frame_h    = 13'd4096;

    // predictor copy of the positions and the line stores
    int               src_row = 0;
    int               src_col = 0;
    int               dst_row = 0;
    int               dst_col = 0;
    bit               hit_rows [LINES][MAX_WIDTH];
    logic [PIX_W-1:0] px_rows  [LINES][MAX_WIDTH];

    color_match_dilation_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // sizes as the block uses them: out of range values are clamped
    function automatic int width_used();
        if (frame_w == 0) return 1;
        return (frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w);
    endfunction

    function automatic int height_used();
        if (frame_h == 0) return 1;
        return (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
    endfunction

    function automatic int radius_used();
        return (win_radius > MAX_RADIUS) ? MAX_RADIUS : int'(win_radius);
    endfunction

    function automatic void rewind_frame();
        src_row = 0;
        src_col = 0;
        dst_row = 0;
        dst_col = 0;
    endfunction

    // advances the predictor by one accepted input transfer and queues the
    // output pixel it releases, if any
    task automatic dilate_transfer(input logic cmd, input logic [PIX_W-1:0] px);
        int               w, h, r, rr, cc, got, done;
        bit               fire, hit, last;
        logic [PIX_W-1:0] color;
        w = width_used();
        h = height_used();
        r = radius_used();
        fire = 1'b0;
        if (src_row >= h) begin
            // frame complete: flush or pixel alike releases one pending pixel
            fire = 1'b1;
        end else if (cmd == cmdil_pkg::CMD_PIXEL) begin
            // match bit is judged against the colour of this moment
            px_rows[src_row % LINES][src_col]  = px;
            hit_rows[src_row % LINES][src_col] = (px == key_color);
            src_col++;
            if (src_col >= w) begin
                src_col = 0;
                src_row++;
            end
            got  = src_row * w + src_col;
            done = dst_row * w + dst_col;
            fire = (got - done > r * w + r);
        end
        // a flush before the frame is complete does nothing
        if (fire) begin
            color = px_rows[dst_row % LINES][dst_col];
            // pixels within r of an edge pass through unchanged
            if (dst_row >= r && dst_row + r < h && dst_col >= r && dst_col + r < w) begin
                hit = 1'b0;
                for (rr = dst_row - r; rr <= dst_row + r; rr++)
                    for (cc = dst_col - r; cc <= dst_col + r; cc++)
                        hit |= hit_rows[rr % LINES][cc];
                // written colour is the one current at output time
                if (hit) color = key_color;
            end
            last = (dst_row + 1 >= h) && (dst_col + 1 >= w);
            owed_pixels.push_back('{color, last});
            if (last) begin
                rewind_frame();
            end else begin
                dst_col++;
                if (dst_col >= w) begin
                    dst_col = 0;
                    dst_row++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: pops pending transfers, idles in random bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed_proc
        pix_xfer_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            feed_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (feed_gap > 0) begin
                feed_gap <= feed_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!steady && pending_xfers.size() != 0 &&
                         $urandom_range(0, 9) == 0) begin
                // idle gap of random length
                feed_gap <= $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end else if (pending_xfers.size() != 0) begin
                nxt = pending_xfers.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= nxt.px;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output sink: stalls in random bursts
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end else if (!steady && $urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: tracks register writes and input transfers, checks outputs
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_proc
        dilated_px_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cmdil_pkg::REG_MATCH_COLOR:  key_color  = cfg_wdata[PIX_W-1:0];
                    cmdil_pkg::REG_RADIUS:       win_radius = cfg_wdata[RAD_W-1:0];
                    cmdil_pkg::REG_IMAGE_WIDTH:  frame_w    = cfg_wdata[SIZE_W-1:0];
                    cmdil_pkg::REG_IMAGE_HEIGHT: frame_h    = cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
                // any geometry write drops the frame in progress
                if (cfg_addr != cmdil_pkg::REG_MATCH_COLOR) rewind_frame();
            end
            if (s_tvalid && s_tready) dilate_transfer(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (owed_pixels.size() == 0) begin
                    fail_count++;
                    $error("unexpected output transfer: pixel_out %06h, frame_last %0b",
                           m_tdata, m_tlast);
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_tdata !== want.color) begin
                        fail_count++;
                        $error("pixel_out: expected %06h, got %06h", want.color, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        fail_count++;
                        $error("frame_last: expected %0b, got %0b", want.last, m_tlast);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one register write; the monitor picks it up
    task automatic write_reg(input cmdil_pkg::cfg_reg_t idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_DW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // block idle: nothing queued, nothing offered, nothing owed, pipeline drained
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_xfers.size() != 0 || s_tvalid || owed_pixels.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    // pixel colours biased toward the key and near misses of it
    function automatic logic [PIX_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0, 1:    return key_color;
            2:       return key_color ^ (24'd1 << $urandom_range(0, 23));
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic send_pixels(input int n);
        repeat (n) begin
            // stray flush before the frame is complete, ignored by the block
            if ($urandom_range(0, 23) == 0)
                pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'($urandom())});
            pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, pick_color()});
            sent++;
        end
    endtask

    // one frame at the current geometry followed by its drain; when allowed,
    // the frame may be interrupted once the block is idle, either to change
    // the colour mid-frame or to leave it for a geometry write to drop
    task automatic send_frame(input bit may_cut, output bit dropped);
        int npx, lag, cut;
        npx = width_used() * height_used();
        lag = radius_used() * width_used() + radius_used();
        if (lag > npx) lag = npx;
        cut = (may_cut && npx > 1 && $urandom_range(0, 7) == 0) ?
              $urandom_range(1, npx - 1) : npx;
        dropped = 1'b0;
        send_pixels(cut);
        if (cut < npx) begin
            wait_quiet();
            if ($urandom_range(0, 1)) begin
                dropped = 1'b1;
                return;
            end
            write_reg(cmdil_pkg::REG_MATCH_COLOR, $urandom_range(0, 24'hFFFFFF));
            send_pixels(npx - cut);
        end
        // drain; a pixel here is discarded and acts as a flush
        repeat (lag) begin
            pending_xfers.push_back('{($urandom_range(0, 3) == 0) ?
                                      cmdil_pkg::CMD_PIXEL : cmdil_pkg::CMD_FLUSH,
                                      pick_color()});
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stim_proc
        bit cut_short;
        int frames;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 3x3 frame, r = 1: key in the top left corner reaches the one interior pixel
        write_reg(cmdil_pkg::REG_MATCH_COLOR, 24'hFFFFFF);
        write_reg(cmdil_pkg::REG_RADIUS, 1);
        write_reg(cmdil_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(cmdil_pkg::REG_IMAGE_HEIGHT, 3);
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'hFFFFFF});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h000000});
        // flush before frame complete
        pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'hA5A5A5});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h123456});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'hFFFFFE});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h7FFFFF});
        wait_quiet();
        // colour change mid-frame: old match bit stays, new colour is written
        write_reg(cmdil_pkg::REG_MATCH_COLOR, 24'h000000);
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h800000});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h000001});
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h000000});
        pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'h000000});
        // last pixel of the frame
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'hFFFFFF});
        pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'h5A5A5A});
        pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'hFFFFFF});
        wait_quiet();

        // clamped sizes: radius 3 acts as 2, zero sizes act as 1; window exceeds frame
        write_reg(cmdil_pkg::REG_RADIUS, 3);
        write_reg(cmdil_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(cmdil_pkg::REG_IMAGE_HEIGHT, 0);
        pending_xfers.push_back('{cmdil_pkg::CMD_PIXEL, 24'h000000});
        pending_xfers.push_back('{cmdil_pkg::CMD_FLUSH, 24'hC3C3C3});
        wait_quiet();

        // partial frame, dropped by the geometry writes that follow
        write_reg(cmdil_pkg::REG_RADIUS, 1);
        write_reg(cmdil_pkg::REG_IMAGE_WIDTH, 4);
        write_reg(cmdil_pkg::REG_IMAGE_HEIGHT, 4);
        send_pixels(6);
        wait_quiet();

        // random frame streams at small random geometries
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_quiet();
            // last stretch runs with both sides always ready
            if (sent >= STEADY_FROM) steady = 1'b1;
            if ($urandom_range(0, 1))
                write_reg(cmdil_pkg::REG_MATCH_COLOR, $urandom_range(0, 24'hFFFFFF));
            write_reg(cmdil_pkg::REG_RADIUS, $urandom_range(0, 3));
            write_reg(cmdil_pkg::REG_IMAGE_WIDTH,
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9));
            write_reg(cmdil_pkg::REG_IMAGE_HEIGHT,
                      ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9));
            cut_short = 1'b0;
            for (frames = $urandom_range(1, 3); frames > 0 && !cut_short; frames--)
                send_frame(1'b1, cut_short);
        end

        wait_quiet();
        repeat (20) @(negedge aclk);
        if (owed_pixels.size() != 0) begin
            fail_count++;
            $error("%0d expected output pixels never arrived", owed_pixels.size());
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/cmdil_pkg.sv
src/cmdil_match_mem.sv
src/cmdil_pixel_mem.sv
src/cmdil_ctrl.sv
src/cmdil_window.sv
src/color_match_dilation_unit.sv
tb/tb_color_match_dilation_unit.sv
